FILE: hdl/ngb_pkg.sv
package ngb_pkg;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} ngb_state_t;

	// Bit positions inside the result tuser
	localparam int unsigned USER_NONE      = 0;
	localparam int unsigned USER_TRUNCATED = 1;
	localparam int unsigned USER_BITS      = 2;

	// Width of the n-gram size register
	localparam int unsigned NGRAM_CFG_BITS = 4;

endpackage

FILE: hdl/ngb_ram.sv
module ngb_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/no_repeat_ngram_ban_top.sv
// Channel   | Signals                          | Contents (low bits first)
// ----------+----------------------------------+----------------------------------------
// input     | s_tvalid s_tready s_tdata s_tuser | tdata: token; tuser: restart
// result    | m_tvalid m_tready m_tdata m_tuser | tdata: banned_token;
//           | m_tlast                          | tuser: none, truncated; tlast: last
// config    | cfg_we cfg_wdata                 | ngram_size
//
// One token per transaction; the block takes the next one only after the last
// result of the previous one has been loaded into the output register.
// Each token passes through these steps before the next one can be taken: its
// acceptance, one read per token in the window (up to HISTORY_DEPTH) from the single
// read port of the history RAM, emptying the compare stage and loading the final
// result.
// Output stalls stop the scan; no result is dropped. Reset clears the window
// count, pointer, overflow flag and n-gram size; the history RAM is not cleared.
module no_repeat_ngram_ban_top
	import ngb_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 64,
	parameter int unsigned MAX_NGRAM     = 8,
	parameter int unsigned TOKEN_BITS    = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input: tdata = token, tuser = restart
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((TOKEN_BITS+7)/8)*8-1:0]       s_tdata,
	input  logic                                  s_tuser,
	// result: tdata = banned_token, tuser = none, truncated
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((TOKEN_BITS+7)/8)*8-1:0]       m_tdata,
	output logic [USER_BITS-1:0]                  m_tuser,
	output logic                                  m_tlast,
	// config: ngram_size
	input  logic                                  cfg_we,
	input  logic [NGRAM_CFG_BITS-1:0]             cfg_wdata
);

	localparam int unsigned DW  = ((TOKEN_BITS + 7) / 8) * 8;
	localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
	localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned NW  = $clog2(MAX_NGRAM + 1);
	localparam int unsigned RW  = (MAX_NGRAM > 1) ? MAX_NGRAM - 1 : 1;
	localparam int unsigned PW  = (CW > NW) ? CW : NW;
	localparam int unsigned CMW = (NW > NGRAM_CFG_BITS) ? NW : NGRAM_CFG_BITS;

	ngb_state_t state_q;

	logic [NGRAM_CFG_BITS-1:0] ngram_size_q;
	logic [NW-1:0]             n_q;
	logic [AW-1:0]             wp_q;
	logic [CW-1:0]             fill_q;
	logic                      ovf_q;

	logic [TOKEN_BITS-1:0]     recent_q [RW];
	logic [TOKEN_BITS-1:0]     win_q    [RW];

	logic [AW-1:0]             rd_addr_q;
	logic [CW-1:0]             rd_left_q;
	logic [CW-1:0]             rd_pos_q;
	logic                      valid_s1;
	logic [CW-1:0]             pos_s1;

	logic                      pend_valid_q;
	logic [TOKEN_BITS-1:0]     pend_tok_q;

	logic                      out_valid_q;
	logic [TOKEN_BITS-1:0]     out_tok_q;
	logic                      out_none_q;
	logic                      out_last_q;
	logic                      out_trunc_q;

	logic                      in_fire;
	logic [AW-1:0]             wp_base;
	logic [CW-1:0]             fill_base;
	logic                      ovf_base;
	logic [AW-1:0]             wp_next;
	logic [CW-1:0]             fill_next;
	logic                      ovf_next;
	logic [CMW-1:0]            cfg_ext;
	logic [NW-1:0]             n_sat;

	logic [TOKEN_BITS-1:0]     rdata;
	logic                      rd_issue;
	logic                      out_free;
	logic [NW-1:0]             p;
	logic                      mism;
	logic                      match_s1;
	logic                      adv_s1;
	logic                      push_pend;
	logic                      finish_load;

	// History RAM
	ngb_ram #(
		.WIDTH(TOKEN_BITS),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (in_fire),
		.waddr(wp_base),
		.wdata(s_tdata[TOKEN_BITS-1:0]),
		.re   (rd_issue),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// Apply restart, then the append
	always_comb begin
		wp_base   = s_tuser ? '0 : wp_q;
		fill_base = s_tuser ? '0 : fill_q;
		ovf_base  = s_tuser ? 1'b0 : ovf_q;
		wp_next   = (wp_base == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_base + AW'(1);
		if (fill_base == CW'(HISTORY_DEPTH)) begin
			fill_next = fill_base;
			ovf_next  = 1'b1;
		end else begin
			fill_next = fill_base + CW'(1);
			ovf_next  = ovf_base;
		end
	end

	// Saturate the n-gram size
	always_comb begin
		cfg_ext = CMW'(ngram_size_q);
		n_sat   = (cfg_ext > CMW'(MAX_NGRAM)) ? NW'(MAX_NGRAM) : NW'(cfg_ext);
	end

	// Prefix compare against the newest tokens
	assign p = n_q - NW'(1);
	always_comb begin
		mism = 1'b0;
		for (int k = 0; k < RW; k++) begin
			if ((PW'(k) < PW'(p)) && (win_q[k] != recent_q[k])) begin
				mism = 1'b1;
			end
		end
	end

	assign out_free    = !out_valid_q || m_tready;
	assign match_s1    = valid_s1 && (n_q != '0) && (PW'(pos_s1) >= PW'(p)) && !mism;
	assign adv_s1      = valid_s1 && (!match_s1 || !pend_valid_q || out_free);
	assign push_pend   = adv_s1 && match_s1 && pend_valid_q;
	assign rd_issue    = (state_q == ST_SCAN) && (rd_left_q != '0) && (!valid_s1 || adv_s1);
	assign finish_load = (state_q == ST_FINISH) && out_free;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ngram_size_q <= '0;
		end else if (cfg_we) begin
			ngram_size_q <= cfg_wdata;
		end
	end

	// Window bookkeeping and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			fill_q       <= '0;
			ovf_q        <= 1'b0;
			n_q          <= '0;
			rd_addr_q    <= '0;
			rd_left_q    <= '0;
			rd_pos_q     <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						wp_q         <= wp_next;
						fill_q       <= fill_next;
						ovf_q        <= ovf_next;
						n_q          <= n_sat;
						rd_addr_q    <= (fill_next == CW'(HISTORY_DEPTH)) ? wp_next : '0;
						rd_left_q    <= fill_next;
						rd_pos_q     <= '0;
						valid_s1     <= 1'b0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Advance the read pointer
					if (rd_issue) begin
						rd_addr_q <= (rd_addr_q == AW'(HISTORY_DEPTH - 1)) ?
							'0 : rd_addr_q + AW'(1);
						rd_left_q <= rd_left_q - CW'(1);
						rd_pos_q  <= rd_pos_q + CW'(1);
						valid_s1  <= 1'b1;
					end else if (adv_s1) begin
						valid_s1 <= 1'b0;
					end
					// Hold the newest match back until the next one or the end
					if (adv_s1 && match_s1) begin
						pend_valid_q <= 1'b1;
					end
					if ((rd_left_q == '0) && !valid_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stage 1 position tracks the read data
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			pos_s1 <= rd_pos_q;
		end
	end

	// Newest tokens, newest in entry 0
	always_ff @(posedge clk) begin
		if (in_fire) begin
			recent_q[0] <= s_tdata[TOKEN_BITS-1:0];
			for (int k = 1; k < RW; k++) begin
				recent_q[k] <= recent_q[k-1];
			end
		end
	end

	// Sliding window of scanned tokens and pending match
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q[0] <= rdata;
			for (int k = 1; k < RW; k++) begin
				win_q[k] <= win_q[k-1];
			end
			if (match_s1) begin
				pend_tok_q <= rdata;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || finish_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the overflow flag with each result so it holds while the result waits
	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_tok_q   <= pend_tok_q;
			out_none_q  <= 1'b0;
			out_last_q  <= 1'b0;
			out_trunc_q <= ovf_q;
		end else if (finish_load) begin
			out_tok_q   <= pend_valid_q ? pend_tok_q : '0;
			out_none_q  <= !pend_valid_q;
			out_last_q  <= 1'b1;
			out_trunc_q <= ovf_q;
		end
	end

	assign m_tvalid                 = out_valid_q;
	assign m_tdata                  = DW'(out_tok_q);
	assign m_tlast                  = out_last_q;
	assign m_tuser[USER_NONE]       = out_none_q;
	assign m_tuser[USER_TRUNCATED]  = out_trunc_q;

endmodule

FILE: tb/sv/no_repeat_ngram_ban_top_tb.sv
module no_repeat_ngram_ban_top_tb
	import ngb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HISTORY_DEPTH = 64;
	localparam int unsigned MAX_NGRAM     = 8;
	localparam int unsigned TOKEN_BITS    = 18;
	localparam int unsigned DATA_BITS     = ((TOKEN_BITS + 7) / 8) * 8;
	localparam int unsigned IDLE_PCT      = 29;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 16;

	typedef logic [TOKEN_BITS-1:0] token_t;

	typedef struct packed {
		token_t token;
		logic   none;
		logic   last;
		logic   truncated;
	} ban_item_t;

	// Tracks the token window, predicts the banned list and checks results
	class ngram_ban_tracker;
		token_t      window_q[$];
		bit          overflow;
		logic [NGRAM_CFG_BITS-1:0] ngram_size;
		ban_item_t   expected_bans[$];
		int          errors;
		int          tokens;
		int          restarts;
		int          checked;
		int          truncated_seen;

		function new();
			overflow   = 1'b0;
			ngram_size = '0;
		endfunction

		function int pending();
			return expected_bans.size();
		endfunction

		// Append one accepted token and queue the bans it causes
		function void note_token(token_t tok, bit restart);
			int unsigned n;
			int unsigned len;
			int unsigned prefix;
			int unsigned cur;
			int          found;
			bit          hit;
			ban_item_t   item;
			tokens++;
			if (restart) begin
				window_q.delete();
				overflow = 1'b0;
				restarts++;
			end
			// drop the oldest token once the window is full
			if (window_q.size() == HISTORY_DEPTH) begin
				void'(window_q.pop_front());
				overflow = 1'b1;
			end
			window_q.insert(window_q.size(), tok);
			n = (ngram_size > MAX_NGRAM) ? MAX_NGRAM : ngram_size;
			len = window_q.size();
			found = 0;
			if (n != 0 && len >= n) begin
				prefix = n - 1;
				cur = len - prefix;
				for (int unsigned s = 0; s + n <= len; s++) begin
					hit = 1'b1;
					for (int unsigned j = 0; j < prefix; j++) begin
						if (window_q[s + j] != window_q[cur + j])
							hit = 1'b0;
					end
					if (hit) begin
						item.token     = window_q[s + prefix];
						item.none      = 1'b0;
						item.last      = 1'b0;
						item.truncated = overflow;
						expected_bans.insert(expected_bans.size(), item);
						found++;
					end
				end
			end
			// empty list: a single marker item
			if (found == 0) begin
				item.token     = '0;
				item.none      = 1'b1;
				item.last      = 1'b1;
				item.truncated = overflow;
				expected_bans.insert(expected_bans.size(), item);
			end else begin
				expected_bans[$].last = 1'b1;
			end
		endfunction

		// Compare one result transaction with the oldest expected ban
		function void check_ban(token_t tok, logic none, logic last, logic truncated);
			ban_item_t exp_item;
			checked++;
			if (truncated === 1'b1)
				truncated_seen++;
			if (expected_bans.size() == 0) begin
				$error("unexpected result: banned_token %0h none %0b last %0b truncated %0b",
					tok, none, last, truncated);
				errors++;
				return;
			end
			exp_item = expected_bans.pop_front();
			if (tok !== exp_item.token) begin
				$error("banned_token: expected %0h, actual %0h", exp_item.token, tok);
				errors++;
			end
			if (none !== exp_item.none) begin
				$error("none: expected %0b, actual %0b", exp_item.none, none);
				errors++;
			end
			if (last !== exp_item.last) begin
				$error("last: expected %0b, actual %0b", exp_item.last, last);
				errors++;
			end
			if (truncated !== exp_item.truncated) begin
				$error("truncated: expected %0b, actual %0b", exp_item.truncated, truncated);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [DATA_BITS-1:0]      s_tdata = '0;
	logic                      s_tuser = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [DATA_BITS-1:0]      m_tdata;
	logic [USER_BITS-1:0]      m_tuser;
	logic                      m_tlast;
	logic                      cfg_we = 1'b0;
	logic [NGRAM_CFG_BITS-1:0] cfg_wdata = '0;

	ngram_ban_tracker bans = new();
	bit               steady_flow = 1'b0;
	int               hold_left = 0;
	bit               hold_done = 1'b0;

	no_repeat_ngram_ban_top #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.MAX_NGRAM    (MAX_NGRAM),
		.TOKEN_BITS   (TOKEN_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Check result transactions, then drive tready with random stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			bans.check_ban(m_tdata[TOKEN_BITS-1:0], m_tuser[USER_NONE], m_tlast,
				m_tuser[USER_TRUNCATED]);
			// hold off once for a long stretch so the input side backs up
			if (!hold_done && bans.checked >= 100) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offer one token, idling at random first, and note it once accepted
	task automatic send_token(input token_t tok, input bit restart);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_BITS'(tok);
		s_tuser  <= restart;
		do
			@(posedge clk);
		while (!s_tready);
		bans.note_token(tok, restart);
	endtask

	// Stop offering and wait until every expected ban has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		while (bans.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ngram_size(input logic [NGRAM_CFG_BITS-1:0] size);
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		bans.ngram_size = size;
	endtask

	// Random phase: tokens mostly from a tiny alphabet so n-grams repeat
	task automatic run_phase(input logic [NGRAM_CFG_BITS-1:0] size, input int count,
		input bit keep_window);
		token_t alphabet[3];
		token_t tok;
		bit     restart;
		drain();
		write_ngram_size(size);
		foreach (alphabet[k])
			alphabet[k] = token_t'($urandom());
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 10)
				tok = token_t'($urandom());
			else
				tok = alphabet[$urandom_range(2)];
			restart = (i == 0) || (!keep_window && $urandom_range(99) < 4);
			send_token(tok, restart);
		end
	endtask

	// Run limit
	initial begin
		#5ms;
		$display("no_repeat_ngram_ban_top: mismatch");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size 0 after reset: banning disabled, token extremes
		send_token('1, 1'b1);
		send_token('0, 1'b0);

		// bigrams: short history, no match, single match, duplicates
		drain();
		write_ngram_size(4'd2);
		send_token(token_t'(5), 1'b1);
		send_token('1, 1'b0);
		send_token(token_t'(5), 1'b0);
		send_token('1, 1'b0);
		send_token(token_t'(5), 1'b0);
		send_token('0, 1'b0);

		// trigrams over a repeating pair
		drain();
		write_ngram_size(4'd3);
		send_token(token_t'(1), 1'b1);
		send_token(token_t'(2), 1'b0);
		send_token(token_t'(1), 1'b0);
		send_token(token_t'(2), 1'b0);
		send_token(token_t'(1), 1'b0);

		// unigrams: every history token is banned
		drain();
		write_ngram_size(4'd1);
		send_token(token_t'(7), 1'b1);
		send_token(token_t'(7), 1'b0);
		send_token(token_t'('h2AAAA), 1'b0);
		send_token(token_t'('h15555), 1'b0);

		// size above the maximum saturates; history still short
		drain();
		write_ngram_size(4'd15);
		send_token(token_t'(9), 1'b1);
		send_token(token_t'(9), 1'b0);
		send_token(token_t'(9), 1'b0);
		send_token(token_t'(9), 1'b0);

		// random phases; the long one overruns the window without restart
		run_phase(4'd2, 30, 1'b0);
		run_phase(4'd3, 80, 1'b1);
		run_phase(4'd1, 10, 1'b0);
		steady_flow = 1'b1;
		run_phase(4'd8, 20, 1'b0);
		drain();
		steady_flow = 1'b0;
		run_phase(4'd15, 15, 1'b0);
		run_phase(4'd4, 15, 1'b0);
		run_phase(4'd0, 10, 1'b0);
		run_phase(4'd6, 10, 1'b0);
		drain();

		$display("covered %0d tokens with %0d restarts over n-gram sizes 0 to 15",
			bans.tokens, bans.restarts);
		$display("checked %0d ban results, %0d of them from a truncated window",
			bans.checked, bans.truncated_seen);
		if (bans.errors == 0 && bans.pending() == 0)
			$display("no_repeat_ngram_ban_top: match");
		else
			$display("no_repeat_ngram_ban_top: mismatch");
		$finish;
	end

endmodule

FILE: files.f
hdl/ngb_pkg.sv
hdl/ngb_ram.sv
hdl/no_repeat_ngram_ban_top.sv
tb/sv/no_repeat_ngram_ban_top_tb.sv
